@@ src/nlsc_pkg.sv @@
// ----------------------------------------------------------------------------
// nlsc_pkg: shared types and constants of the night light schedule controller
// Payload structs, register indexes, operation codes and ramp arithmetic
// constants used by every module of the block.
// ----------------------------------------------------------------------------
package nlsc_pkg;

  localparam int unsigned TIME_W    = 27;
  localparam int unsigned TEMP_W    = 15;
  localparam int unsigned NIGHT_W   = 13;
  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned WIDE_W    = TIME_W + 1;   // time plus ramp length
  localparam int unsigned ELAPSED_W = 22;           // holds up to one hour in ms
  localparam int unsigned PROD_W    = NIGHT_W + ELAPSED_W;
  localparam int unsigned PROD_SHIFT = 7;           // 3600000 = 2^7 * 28125
  localparam int unsigned P7_W      = PROD_W - PROD_SHIFT;
  localparam int unsigned RECIP_W   = 29;
  localparam int unsigned RECIP_SHIFT = 43;
  localparam int unsigned QPROD_W   = P7_W + RECIP_W;

  localparam logic [NIGHT_W-1:0] DAY_K         = 13'd6500;
  localparam logic [NIGHT_W-1:0] NIGHT_RESET_K = 13'd5000;
  localparam logic [WIDE_W-1:0]  RAMP_MS       = 28'd3600000;
  // ceil(2^43 / 28125): exact floor division by 28125 for 28-bit dividends
  localparam logic [RECIP_W-1:0] RECIP_M       = 29'd312749975;

  localparam logic [1:0] OP_TICK        = 2'd0;
  localparam logic [1:0] OP_OVERRIDE    = 2'd1;
  localparam logic [1:0] OP_PREVIEW     = 2'd2;
  localparam logic [1:0] OP_END_PREVIEW = 2'd3;

  localparam logic [1:0] REG_WINDOW_START = 2'd0;
  localparam logic [1:0] REG_WINDOW_END   = 2'd1;
  localparam logic [1:0] REG_NIGHT_TEMP   = 2'd2;
  localparam logic [1:0] REG_PAUSED       = 2'd3;

  typedef struct packed {
    logic [1:0]        operation;
    logic [TIME_W-1:0] time_of_day_ms;
    logic              override_enable;
    logic [TEMP_W-1:0] preview_temperature;
  } nlsc_in_t;

  typedef struct packed {
    logic              temperature_valid;
    logic [TEMP_W-1:0] temperature;
    logic              enable_event;
    logic              enabled_level;
  } nlsc_out_t;

  typedef struct packed {
    logic [TIME_W-1:0]  window_start_ms;
    logic [TIME_W-1:0]  window_end_ms;
    logic [NIGHT_W-1:0] night_temperature;
    logic               schedule_paused;
  } nlsc_cfg_t;

  // Item fields that ride along the target pipeline to the state stage
  typedef struct packed {
    logic [1:0]        operation;
    logic              override_enable;
    logic [TEMP_W-1:0] preview_temperature;
  } nlsc_side_t;

  // Stage load strobes from the handshake control
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } nlsc_pipe_ctl_t;

endpackage

@@ src/nlsc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// nlsc_cfg_regs: configuration register file
// APB-style write and read of the window, night temperature and pause bit.
// ----------------------------------------------------------------------------
module nlsc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nlsc_pkg::ADDR_W-1:0] paddr,
  input  logic [nlsc_pkg::DATA_W-1:0] pwdata,
  output logic [nlsc_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output nlsc_pkg::nlsc_cfg_t         cfg
);
  import nlsc_pkg::*;

  nlsc_cfg_t  cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_start_ms   <= '0;
      cfg_r.window_end_ms     <= '0;
      cfg_r.night_temperature <= NIGHT_RESET_K;
      cfg_r.schedule_paused   <= 1'b1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WINDOW_START: cfg_r.window_start_ms   <= pwdata[TIME_W-1:0];
        REG_WINDOW_END:   cfg_r.window_end_ms     <= pwdata[TIME_W-1:0];
        REG_NIGHT_TEMP:   cfg_r.night_temperature <= pwdata[NIGHT_W-1:0];
        REG_PAUSED:       cfg_r.schedule_paused   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WINDOW_START: prdata = DATA_W'(cfg_r.window_start_ms);
      REG_WINDOW_END:   prdata = DATA_W'(cfg_r.window_end_ms);
      REG_NIGHT_TEMP:   prdata = DATA_W'(cfg_r.night_temperature);
      REG_PAUSED:       prdata = DATA_W'(cfg_r.schedule_paused);
      default:          prdata = '0;
    endcase
  end

endmodule

@@ src/nlsc_target.sv @@
// ----------------------------------------------------------------------------
// nlsc_target: scheduled target temperature pipeline
// Window compare, ramp product and reciprocal division over three stages.
// ----------------------------------------------------------------------------
module nlsc_target (
  input  logic                         clk,
  input  nlsc_pkg::nlsc_pipe_ctl_t     ctl,
  input  nlsc_pkg::nlsc_cfg_t          cfg,
  input  nlsc_pkg::nlsc_in_t           s0_item,
  output nlsc_pkg::nlsc_side_t         s3_side,
  output logic [nlsc_pkg::NIGHT_W-1:0] sched_target
);
  import nlsc_pkg::*;

  typedef enum logic [1:0] {
    TK_DAY,
    TK_NIGHT,
    TK_RAMP
  } kind_t;

  // stage 0 combinational
  logic [TIME_W-1:0]    t;
  logic [TIME_W-1:0]    ws;
  logic [TIME_W-1:0]    we;
  logic [WIDE_W-1:0]    t_plus;
  logic [WIDE_W-1:0]    e_plus;
  logic                 in_window;
  logic                 ramp_in;
  logic                 ramp_out;
  kind_t                kind0;
  logic [WIDE_W-1:0]    elapsed_w;
  logic                 neg0;
  logic [NIGHT_W-1:0]   absdiff0;
  nlsc_side_t           side0;

  // stage registers
  kind_t                s1_kind_r, s2_kind_r, s3_kind_r;
  logic                 s1_neg_r, s2_neg_r, s3_neg_r;
  nlsc_side_t           s1_side_r, s2_side_r, s3_side_r;
  logic [ELAPSED_W-1:0] s1_elapsed_r;
  logic [NIGHT_W-1:0]   s1_absdiff_r;
  logic [P7_W-1:0]      s2_p7_r;
  logic [NIGHT_W-1:0]   s3_q_r;

  logic [PROD_W-1:0]    prod1;
  logic [QPROD_W-1:0]   qprod2;

  always_comb begin
    t      = s0_item.time_of_day_ms;
    ws     = cfg.window_start_ms;
    we     = cfg.window_end_ms;
    t_plus = WIDE_W'(t) + RAMP_MS;
    e_plus = WIDE_W'(we) + RAMP_MS;

    if (ws > we) begin
      in_window = (t < we) || (t > ws);
    end else begin
      in_window = (t < we) && (t > ws);
    end
    ramp_in  = (t < ws) && (t_plus > WIDE_W'(ws));
    ramp_out = (t > we) && (WIDE_W'(t) < e_plus);

    elapsed_w = '0;
    if (in_window) begin
      kind0 = TK_NIGHT;
    end else if (ramp_in) begin
      kind0     = TK_RAMP;
      elapsed_w = t_plus - WIDE_W'(ws);
    end else if (ramp_out) begin
      kind0     = TK_RAMP;
      elapsed_w = e_plus - WIDE_W'(t);
    end else begin
      kind0 = TK_DAY;
    end

    neg0     = cfg.night_temperature > DAY_K;
    absdiff0 = neg0 ? (cfg.night_temperature - DAY_K) : (DAY_K - cfg.night_temperature);

    side0.operation           = s0_item.operation;
    side0.override_enable     = s0_item.override_enable;
    side0.preview_temperature = s0_item.preview_temperature;
  end

  assign prod1  = PROD_W'(s1_absdiff_r) * PROD_W'(s1_elapsed_r);
  assign qprod2 = QPROD_W'(s2_p7_r) * QPROD_W'(RECIP_M);

  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      s1_kind_r    <= kind0;
      s1_neg_r     <= neg0;
      s1_side_r    <= side0;
      s1_elapsed_r <= elapsed_w[ELAPSED_W-1:0];
      s1_absdiff_r <= absdiff0;
    end
    if (ctl.ld2) begin
      s2_kind_r <= s1_kind_r;
      s2_neg_r  <= s1_neg_r;
      s2_side_r <= s1_side_r;
      s2_p7_r   <= prod1[PROD_W-1:PROD_SHIFT];
    end
    if (ctl.ld3) begin
      s3_kind_r <= s2_kind_r;
      s3_neg_r  <= s2_neg_r;
      s3_side_r <= s2_side_r;
      s3_q_r    <= qprod2[RECIP_SHIFT +: NIGHT_W];
    end
  end

  always_comb begin
    case (s3_kind_r)
      TK_NIGHT: sched_target = cfg.night_temperature;
      TK_RAMP:  sched_target = s3_neg_r ? (DAY_K + s3_q_r) : (DAY_K - s3_q_r);
      default:  sched_target = DAY_K;
    endcase
  end

  assign s3_side = s3_side_r;

endmodule

@@ src/nlsc_state.sv @@
// ----------------------------------------------------------------------------
// nlsc_state: mode state and result register
// Applies override, preview and enable rules and registers the result beat.
// ----------------------------------------------------------------------------
module nlsc_state (
  input  logic                         clk,
  input  logic                         rst_n,
  input  nlsc_pkg::nlsc_cfg_t          cfg,
  input  nlsc_pkg::nlsc_side_t         side,
  input  logic [nlsc_pkg::NIGHT_W-1:0] sched_target,
  input  logic                         fire,
  input  logic                         out_free,
  output logic                         out_valid,
  output nlsc_pkg::nlsc_out_t          out_data
);
  import nlsc_pkg::*;

  typedef enum logic [1:0] {
    OM_NONE,
    OM_OFF,
    OM_ON
  } om_t;

  om_t               om_r, om_nxt;
  logic              sched_active_r, sched_active_nxt;
  logic              eff_on_r, eff_on_nxt;
  logic              preview_r, preview_nxt;
  logic [TEMP_W-1:0] applied_r, applied_nxt;
  logic              out_valid_r;
  nlsc_out_t         out_data_r;

  logic [NIGHT_W-1:0] tgt;
  logic               do_eval;
  logic               evt;
  logic               chg;
  logic               has_res;
  nlsc_out_t          res;

  always_comb begin
    om_nxt           = om_r;
    sched_active_nxt = sched_active_r;
    eff_on_nxt       = eff_on_r;
    preview_nxt      = preview_r;
    applied_nxt      = applied_r;
    tgt              = DAY_K;
    do_eval          = 1'b0;
    evt              = 1'b0;
    chg              = 1'b0;
    has_res          = 1'b0;
    res              = '0;

    case (side.operation)
      OP_TICK: begin
        do_eval = !preview_r;
      end
      OP_OVERRIDE: begin
        if (eff_on_r) begin
          om_nxt = side.override_enable ? OM_NONE : OM_OFF;
        end else begin
          om_nxt = side.override_enable ? OM_ON : OM_NONE;
        end
      end
      OP_PREVIEW: begin
        preview_nxt             = 1'b1;
        applied_nxt             = side.preview_temperature;
        has_res                 = 1'b1;
        res.temperature_valid   = 1'b1;
        res.temperature         = side.preview_temperature;
        res.enable_event        = 1'b0;
        res.enabled_level       = eff_on_r;
      end
      default: begin
        preview_nxt = 1'b0;
        do_eval     = 1'b1;
      end
    endcase

    if (do_eval) begin
      if (!cfg.schedule_paused) begin
        tgt = sched_target;
        // an override clears itself once the schedule reaches its phase
        case (om_r)
          OM_OFF: begin
            if (tgt == DAY_K) begin
              om_nxt = OM_NONE;
            end else begin
              tgt = DAY_K;
            end
          end
          OM_ON: begin
            if (tgt != DAY_K) begin
              om_nxt = OM_NONE;
            end else begin
              tgt = cfg.night_temperature;
            end
          end
          OM_NONE: ;
          default: tgt = cfg.night_temperature;
        endcase
        sched_active_nxt = 1'b1;
        if ((tgt == DAY_K) && eff_on_r) begin
          eff_on_nxt = 1'b0;
          evt        = 1'b1;
        end else if ((tgt != DAY_K) && !eff_on_r) begin
          eff_on_nxt = 1'b1;
          evt        = 1'b1;
        end
      end else begin
        tgt = (om_r == OM_ON) ? cfg.night_temperature : DAY_K;
        if (sched_active_r) begin
          sched_active_nxt = 1'b0;
          eff_on_nxt       = 1'b0;
          evt              = 1'b1;
        end
      end
      chg = TEMP_W'(tgt) != applied_r;
      if (chg) begin
        applied_nxt = TEMP_W'(tgt);
      end
      has_res               = chg || evt;
      res.temperature_valid = chg;
      res.temperature       = applied_nxt;
      res.enable_event      = evt;
      res.enabled_level     = eff_on_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      om_r           <= OM_NONE;
      sched_active_r <= 1'b0;
      eff_on_r       <= 1'b0;
      preview_r      <= 1'b0;
      applied_r      <= TEMP_W'(DAY_K);
      out_valid_r    <= 1'b0;
    end else begin
      if (fire) begin
        om_r           <= om_nxt;
        sched_active_r <= sched_active_nxt;
        eff_on_r       <= eff_on_nxt;
        preview_r      <= preview_nxt;
        applied_r      <= applied_nxt;
      end
      if (out_free) begin
        out_valid_r <= fire && has_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && fire && has_res) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ src/night_light_schedule_controller.sv @@
// ----------------------------------------------------------------------------
// night_light_schedule_controller: display color temperature scheduler
// A result beat passes the input register, the compare, product and
// reciprocal stages, the state stage and the result register.
// Throughput: one item per cycle unless the result side stalls; the ramp
// multiply and reciprocal divide by 3600000 own a stage each, no iteration.
// Reset: synchronous rst_n clears pipeline valids, mode state and the
// registers to their defaults (window 0..0, night 5000 K, schedule paused).
// ----------------------------------------------------------------------------
module night_light_schedule_controller (
  input  logic                        clk,
  input  logic                        rst_n,
  // item channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  nlsc_pkg::nlsc_in_t          in_data,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output nlsc_pkg::nlsc_out_t         out_data,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nlsc_pkg::ADDR_W-1:0] paddr,
  input  logic [nlsc_pkg::DATA_W-1:0] pwdata,
  output logic [nlsc_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import nlsc_pkg::*;

  nlsc_cfg_t          cfg;
  nlsc_pipe_ctl_t     ctl;
  nlsc_side_t         s3_side;
  logic [NIGHT_W-1:0] sched_target;

  // Stage valids: v0 is the input register, v1..v3 the target pipeline.
  logic v0_r, v1_r, v2_r, v3_r;
  logic rdy0, rdy1, rdy2, rdy3, rdy_out;
  logic fire;
  nlsc_in_t s0_r;

  // A stage takes a new beat when it is empty or its beat moves on.
  // A full stage holds only if later stages are full and the result stalls.
  assign rdy_out = !out_valid || !out_stall;
  assign rdy3    = !v3_r || rdy_out;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;
  assign rdy0    = !v0_r || rdy1;

  assign in_stall = !rdy0;

  assign ctl.ld1 = v0_r && rdy1;
  assign ctl.ld2 = v1_r && rdy2;
  assign ctl.ld3 = v2_r && rdy3;

  // The state stage commits its item when the result register can take it;
  // items that yield no result still pass through here to update state.
  assign fire = v3_r && rdy_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // Capture the item beat on acceptance.
  always_ff @(posedge clk) begin
    if (in_valid && rdy0) begin
      s0_r <= in_data;
    end
  end

  nlsc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Window compare, ramp product and exact divide by one hour.
  nlsc_target u_target (
    .clk          (clk),
    .ctl          (ctl),
    .cfg          (cfg),
    .s0_item      (s0_r),
    .s3_side      (s3_side),
    .sched_target (sched_target)
  );

  // Override, preview and enable rules plus the result register.
  nlsc_state u_state (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .side         (s3_side),
    .sched_target (sched_target),
    .fire         (fire),
    .out_free     (rdy_out),
    .out_valid    (out_valid),
    .out_data     (out_data)
  );

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: night light schedule controller testbench
// Drives a directed script of items and register writes, then random phases
// with fresh register settings. Expected beats come from script rows or an
// in-bench model of schedule, override and preview logic, compared by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nlsc_pkg::*;

  localparam longint NEUTRAL_K   = longint'(DAY_K);
  localparam longint RAMP_LEN    = longint'(RAMP_MS);
  localparam longint DAY_MS      = 86400000;
  localparam longint MAX_T       = 134217727;       // all ones in 27 bits
  localparam int     QUIET_LIMIT = 1000;
  localparam int     LONG_HOLD   = 150;
  localparam int     SETTLE_CYC  = 8;                // pipeline latency plus margin

  typedef enum logic [1:0] {MODE_NONE = 2'd0, MODE_OFF = 2'd1, MODE_ON = 2'd2} ovr_mode_e;
  typedef enum {STEP_ITEM, STEP_REG} step_kind_e;
  typedef enum {CHK_MODEL, CHK_NONE, CHK_TYPED} check_e;

  typedef struct {
    step_kind_e  kind;
    check_e      chk;
    nlsc_in_t    item;
    logic [1:0]  reg_idx;
    logic [31:0] value;
    nlsc_out_t   want;
  } script_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  nlsc_in_t            in_data;
  logic                out_valid;
  logic                out_stall;
  nlsc_out_t           out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Model copy of the registers and the controller state, at reset values
  logic [TIME_W-1:0]   cfg_start  = '0;
  logic [TIME_W-1:0]   cfg_end    = '0;
  logic [NIGHT_W-1:0]  cfg_night  = NIGHT_RESET_K;
  logic                cfg_paused = 1'b1;
  ovr_mode_e           ovr_mode   = MODE_NONE;
  logic                sched_on   = 1'b0;
  logic                night_on   = 1'b0;
  logic                previewing = 1'b0;
  logic [TEMP_W-1:0]   applied_k  = TEMP_W'(6500);

  nlsc_out_t           pending_settings[$];
  int                  fail_cnt    = 0;
  int                  quiet_cycles = 0;
  bit                  rx_calm     = 1'b0;
  bit                  rx_hold_req = 1'b0;

  night_light_schedule_controller u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Schedule model
  // --------------------------------------------------------------------------

  // Linear ramp between neutral and night; the quotient truncates toward zero,
  // which also covers night temperatures above neutral (upward ramps).
  function automatic longint ramp_k(longint night_k, longint elapsed);
    return NEUTRAL_K - (NEUTRAL_K - night_k) * elapsed / RAMP_LEN;
  endfunction

  // Target temperature of the schedule at time t; ramps do not wrap midnight
  // and exact boundary times fall back to neutral.
  function automatic longint sched_target_k(longint t);
    longint s;
    longint e;
    longint nk;
    bit     inside_night;
    s  = cfg_start;
    e  = cfg_end;
    nk = cfg_night;
    if (s > e) inside_night = (t < e) || (t > s);
    else       inside_night = (t < e) && (t > s);
    if (inside_night) return nk;
    if (t < s && t > s - RAMP_LEN) return ramp_k(nk, t - (s - RAMP_LEN));
    if (t > e && t < e + RAMP_LEN) return ramp_k(nk, e + RAMP_LEN - t);
    return NEUTRAL_K;
  endfunction

  // Run the schedule at time t, fold in the override, update the enable
  // state and the applied temperature. Returns 1 when a beat is due.
  function automatic bit settle_schedule(longint t, output nlsc_out_t res);
    longint tgt;
    bit     ev;
    bit     chg;
    ev = 1'b0;
    if (!cfg_paused) begin
      tgt = sched_target_k(t);
      if (ovr_mode != MODE_NONE) begin
        // Overrides clear themselves once the schedule reaches their phase
        if (tgt == NEUTRAL_K && ovr_mode == MODE_OFF) ovr_mode = MODE_NONE;
        else if (tgt != NEUTRAL_K && ovr_mode == MODE_ON) ovr_mode = MODE_NONE;
        else if (ovr_mode == MODE_OFF) tgt = NEUTRAL_K;
        else tgt = cfg_night;
      end
      sched_on = 1'b1;
      if (tgt == NEUTRAL_K && night_on) begin
        night_on = 1'b0;
        ev = 1'b1;
      end else if (tgt != NEUTRAL_K && !night_on) begin
        night_on = 1'b1;
        ev = 1'b1;
      end
    end else begin
      tgt = (ovr_mode == MODE_ON) ? longint'(cfg_night) : NEUTRAL_K;
      // Pausing a running schedule always signals the drop, even from off
      if (sched_on) begin
        sched_on = 1'b0;
        night_on = 1'b0;
        ev = 1'b1;
      end
    end
    chg = (tgt != longint'(applied_k));
    if (chg) applied_k = tgt[TEMP_W-1:0];
    res = '{chg, applied_k, ev, night_on};
    return chg || ev;
  endfunction

  // Advance the model by one accepted item
  function automatic bit next_light_setting(nlsc_in_t it, output nlsc_out_t res);
    res = '0;
    case (it.operation)
      OP_TICK: begin
        if (previewing) return 1'b0;
        return settle_schedule(it.time_of_day_ms, res);
      end
      OP_OVERRIDE: begin
        if (night_on) ovr_mode = it.override_enable ? MODE_NONE : MODE_OFF;
        else          ovr_mode = it.override_enable ? MODE_ON : MODE_NONE;
        return 1'b0;
      end
      OP_PREVIEW: begin
        previewing = 1'b1;
        applied_k  = it.preview_temperature;
        res = '{1'b1, it.preview_temperature, 1'b0, night_on};
        return 1'b1;
      end
      default: begin
        previewing = 1'b0;
        return settle_schedule(it.time_of_day_ms, res);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic nlsc_out_t beat(bit tv, int unsigned k, bit ev, bit lvl);
    nlsc_out_t b;
    b.temperature_valid = tv;
    b.temperature       = TEMP_W'(k);
    b.enable_event      = ev;
    b.enabled_level     = lvl;
    return b;
  endfunction

  function automatic script_row_t item_row(logic [1:0] op, longint t, bit ovr,
                                           int unsigned pk, check_e chk, nlsc_out_t want);
    script_row_t r;
    r.kind                     = STEP_ITEM;
    r.chk                      = chk;
    r.item.operation           = op;
    r.item.time_of_day_ms      = t[TIME_W-1:0];
    r.item.override_enable     = ovr;
    r.item.preview_temperature = TEMP_W'(pk);
    r.reg_idx                  = REG_WINDOW_START;
    r.value                    = '0;
    r.want                     = want;
    return r;
  endfunction

  function automatic script_row_t reg_row(logic [1:0] idx, longint value);
    script_row_t r;
    r         = item_row(OP_TICK, 0, 1'b0, 0, CHK_NONE, '0);
    r.kind    = STEP_REG;
    r.reg_idx = idx;
    r.value   = value[31:0];
    return r;
  endfunction

  // Times cluster around the window edges and ramp limits, with some spread
  // over the day and over the full field range.
  function automatic logic [TIME_W-1:0] random_time();
    longint t;
    int     r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      t = longint'($urandom_range(0, 32'(DAY_MS - 1)));
    end else if (r < 25) begin
      t = longint'($urandom_range(0, 32'(MAX_T)));
    end else begin
      case ($urandom_range(0, 3))
        0:       t = cfg_start;
        1:       t = cfg_end;
        2:       t = longint'(cfg_start) - RAMP_LEN;
        default: t = longint'(cfg_end) + RAMP_LEN;
      endcase
      if (r < 40) t = t + longint'($urandom_range(0, 2)) - 1;
      else        t = t + longint'($urandom_range(0, 7400000)) - 3700000;
    end
    if (t < 0 || t > MAX_T) t = longint'($urandom_range(0, 32'(DAY_MS - 1)));
    return t[TIME_W-1:0];
  endfunction

  function automatic nlsc_in_t random_item();
    nlsc_in_t it;
    int       r;
    r = $urandom_range(0, 99);
    if (r < 55)      it.operation = OP_TICK;
    else if (r < 70) it.operation = OP_OVERRIDE;
    else if (r < 80) it.operation = OP_PREVIEW;
    else             it.operation = OP_END_PREVIEW;
    it.time_of_day_ms      = random_time();
    it.override_enable     = 1'($urandom_range(0, 1));
    it.preview_temperature = TEMP_W'($urandom_range(0, 32767));
    return it;
  endfunction

  // Mostly back to back, some short gaps, a few long ones
  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  // Offer one beat after a gap and hold it until accepted, then log what the
  // model expects from it. Valid stays high when the next call has no gap.
  task automatic send_item(nlsc_in_t it, int gap, check_e chk, nlsc_out_t want);
    nlsc_out_t got;
    bit        has;
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_stall !== 1'b0);
    has = next_light_setting(it, got);
    if (chk == CHK_TYPED) pending_settings.push_back(want);
    else if (chk == CHK_MODEL && has) pending_settings.push_back(got);
  endtask

  // Drop valid, wait for every expected beat, then let the pipeline empty
  // of items that produce nothing.
  task automatic drain_and_settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_settings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the
  // access edge. Mirror it into the model there.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_WINDOW_START: cfg_start  = value[TIME_W-1:0];
      REG_WINDOW_END:   cfg_end    = value[TIME_W-1:0];
      REG_NIGHT_TEMP:   cfg_night  = value[NIGHT_W-1:0];
      REG_PAUSED:       cfg_paused = value[0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result side: stall pattern, long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int hold_left;
    int r;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (rx_calm) begin
        out_stall = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_stall = 1'b0;
        end else if (r < 95) begin
          out_stall = 1'b1;
          hold_left = $urandom_range(0, 2);
        end else begin
          out_stall = 1'b1;
          hold_left = $urandom_range(5, 30);
        end
      end
    end
  end

  // Compare each accepted result beat with the oldest expectation
  always @(posedge clk) begin
    nlsc_out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_settings.size() == 0) begin
        $error("result beat with nothing expected: %p", out_data);
        fail_cnt++;
      end else begin
        want = pending_settings.pop_front();
        if (out_data.temperature_valid !== want.temperature_valid) begin
          $error("temperature_valid: expected %0d, got %0d",
                 want.temperature_valid, out_data.temperature_valid);
          fail_cnt++;
        end
        if (out_data.temperature !== want.temperature) begin
          $error("temperature: expected %0d, got %0d", want.temperature, out_data.temperature);
          fail_cnt++;
        end
        if (out_data.enable_event !== want.enable_event) begin
          $error("enable_event: expected %0d, got %0d", want.enable_event, out_data.enable_event);
          fail_cnt++;
        end
        if (out_data.enabled_level !== want.enabled_level) begin
          $error("enabled_level: expected %0d, got %0d",
                 want.enabled_level, out_data.enabled_level);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0)
        || (psel === 1'b1 && penable === 1'b1)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    script_row_t script[$];
    longint      w_start;
    longint      w_end;
    longint      night;
    bit          paused;
    nlsc_in_t    it;

    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    rst_n    = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: schedule paused, window 0..0, night 5000 K
    script.push_back(item_row(OP_TICK, 0, 1'b0, 0, CHK_NONE, '0));
    script.push_back(item_row(OP_TICK, MAX_T, 1'b0, 0, CHK_NONE, '0));
    script.push_back(item_row(OP_PREVIEW, 0, 1'b0, 25000, CHK_TYPED, beat(1, 25000, 0, 0)));
    // tick while previewing is dropped
    script.push_back(item_row(OP_TICK, 1000, 1'b0, 0, CHK_NONE, '0));
    // preview repeats even an equal temperature; use the field maximum
    script.push_back(item_row(OP_PREVIEW, 0, 1'b0, 32767, CHK_TYPED, beat(1, 32767, 0, 0)));
    script.push_back(item_row(OP_END_PREVIEW, 0, 1'b0, 0, CHK_TYPED, beat(1, 6500, 0, 0)));
    // end of preview with no preview running acts as a tick
    script.push_back(item_row(OP_END_PREVIEW, 5, 1'b0, 0, CHK_NONE, '0));
    // forced on while paused applies the night temperature
    script.push_back(item_row(OP_OVERRIDE, 0, 1'b1, 0, CHK_NONE, '0));
    script.push_back(item_row(OP_TICK, 0, 1'b0, 0, CHK_TYPED, beat(1, 5000, 0, 0)));
    script.push_back(item_row(OP_OVERRIDE, 0, 1'b0, 0, CHK_NONE, '0));
    script.push_back(item_row(OP_TICK, 0, 1'b0, 0, CHK_TYPED, beat(1, 6500, 0, 0)));

    // Wrapping window 22:00 to 06:00, 3000 K, schedule running
    script.push_back(reg_row(REG_WINDOW_START, 79200000));
    script.push_back(reg_row(REG_WINDOW_END, 21600000));
    script.push_back(reg_row(REG_NIGHT_TEMP, 3000));
    script.push_back(reg_row(REG_PAUSED, 0));
    script.push_back(item_row(OP_TICK, 43200000, 1'b0, 0, CHK_NONE, '0));
    script.push_back(item_row(OP_TICK, 0, 1'b0, 0, CHK_TYPED, beat(1, 3000, 1, 1)));
    script.push_back(item_row(OP_TICK, 77400000, 1'b0, 0, CHK_MODEL, '0));   // mid ramp-in
    script.push_back(item_row(OP_TICK, 21600000, 1'b0, 0, CHK_MODEL, '0));   // exact end
    script.push_back(item_row(OP_TICK, 22600000, 1'b0, 0, CHK_MODEL, '0));   // ramp-out
    // forced off during the ramp, cleared once the schedule reaches day
    script.push_back(item_row(OP_OVERRIDE, 0, 1'b0, 0, CHK_NONE, '0));
    script.push_back(item_row(OP_TICK, 22600001, 1'b0, 0, CHK_MODEL, '0));
    script.push_back(item_row(OP_TICK, 43200000, 1'b0, 0, CHK_MODEL, '0));
    // forced on during the day
    script.push_back(item_row(OP_OVERRIDE, 0, 1'b1, 0, CHK_NONE, '0));
    script.push_back(item_row(OP_TICK, 43200000, 1'b0, 0, CHK_MODEL, '0));
    // night above neutral: the ramp runs upward
    script.push_back(reg_row(REG_NIGHT_TEMP, 8191));
    script.push_back(item_row(OP_TICK, 78000000, 1'b0, 0, CHK_MODEL, '0));
    // pausing a running schedule signals the drop
    script.push_back(reg_row(REG_PAUSED, 1));
    script.push_back(item_row(OP_TICK, 0, 1'b0, 0, CHK_MODEL, '0));
    script.push_back(item_row(OP_OVERRIDE, 0, 1'b0, 0, CHK_NONE, '0));
    // pause again with the schedule running but night already off
    script.push_back(reg_row(REG_PAUSED, 0));
    script.push_back(item_row(OP_TICK, 43200000, 1'b0, 0, CHK_MODEL, '0));
    script.push_back(reg_row(REG_PAUSED, 1));
    script.push_back(item_row(OP_TICK, 43200000, 1'b0, 0, CHK_TYPED, beat(0, 6500, 1, 0)));
    // plain window 01:00 to 02:00: no ramp-in before midnight
    script.push_back(reg_row(REG_WINDOW_START, 3600000));
    script.push_back(reg_row(REG_WINDOW_END, 7200000));
    script.push_back(reg_row(REG_NIGHT_TEMP, 1000));
    script.push_back(reg_row(REG_PAUSED, 0));
    script.push_back(item_row(OP_TICK, 5000000, 1'b0, 0, CHK_MODEL, '0));
    script.push_back(item_row(OP_TICK, 0, 1'b0, 0, CHK_MODEL, '0));

    foreach (script[i]) begin
      if (script[i].kind == STEP_REG) begin
        drain_and_settle();
        write_reg(script[i].reg_idx, script[i].value);
      end else begin
        send_item(script[i].item, $urandom_range(0, 2), script[i].chk, script[i].want);
      end
    end

    // Random phases, each under a fresh register setting
    for (int ph = 0; ph < 10; ph++) begin
      drain_and_settle();
      if (ph == 0) begin
        w_start = 0;
        w_end   = MAX_T;
        night   = 0;
      end else if (ph == 1) begin
        w_start = MAX_T;
        w_end   = 0;
        night   = 8191;
      end else begin
        case ($urandom_range(0, 5))
          0: begin
            w_start = 0;
            w_end   = 0;
          end
          1: begin
            w_start = longint'($urandom_range(0, 32'(DAY_MS - 1)));
            w_end   = w_start;
          end
          2: begin
            w_start = longint'($urandom_range(0, 32'(MAX_T)));
            w_end   = longint'($urandom_range(0, 32'(MAX_T)));
          end
          default: begin
            w_start = longint'($urandom_range(0, 32'(DAY_MS - 1)));
            w_end   = longint'($urandom_range(0, 32'(DAY_MS - 1)));
          end
        endcase
        case ($urandom_range(0, 7))
          0:       night = 1000;
          1:       night = 6500;
          2:       night = 8191;
          3:       night = longint'($urandom_range(0, 8191));
          default: night = longint'($urandom_range(1000, 6500));
        endcase
      end
      paused = ($urandom_range(0, 4) == 0);
      write_reg(REG_WINDOW_START, w_start[31:0]);
      write_reg(REG_WINDOW_END, w_end[31:0]);
      write_reg(REG_NIGHT_TEMP, night[31:0]);
      write_reg(REG_PAUSED, {31'd0, paused});

      rx_calm = (ph % 4 == 2);

      // Hold off the result side while previews pour in back to back, so the
      // pipeline fills and stalls its input; then wait for every beat.
      if (ph == 5) begin
        rx_hold_req = 1'b1;
        for (int k = 0; k < 24; k++) begin
          it                     = random_item();
          it.operation           = OP_PREVIEW;
          send_item(it, 0, CHK_MODEL, '0);
        end
        drain_and_settle();
      end

      for (int k = 0; k < 38; k++) begin
        send_item(random_item(), rx_calm ? 0 : random_gap(), CHK_MODEL, '0);
      end
    end

    drain_and_settle();
    repeat (20) @(posedge clk);
    if (fail_cnt == 0 && pending_settings.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/nlsc_pkg.sv
src/nlsc_cfg_regs.sv
src/nlsc_target.sv
src/nlsc_state.sv
src/night_light_schedule_controller.sv
tb/sv/tb_top.sv
